// ===== rtl/core/sitl_pkg.sv =====
// Shared types and constants for the sorted interval table lookup core.
package sitl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int FRAME_W = 24;
  localparam int TAG_W = 12;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef struct packed {
    logic [1:0]         mode;
    logic [FRAME_W-1:0] first_frame;
    logic [FRAME_W-1:0] limit_frame;
    logic [TAG_W-1:0]   tag;
    logic [FRAME_W-1:0] frame;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic [TAG_W-1:0] hit_tag;
    logic [1:0]       insert_status;
  } out_t;

  typedef struct packed {
    logic [FRAME_W-1:0] first_frame;
    logic [FRAME_W-1:0] limit_frame;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEARCH_CMP,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE
  } state_t;

endpackage

// ===== rtl/core/sorted_interval_table_lookup_core.sv =====
// Sorted interval table lookup core: sequencer, table memory and shared comparator.
//
// Keeps up to TABLE_DEPTH intervals sorted by start frame in one single-port-read
// memory. An item is taken when start is high and busy is low; busy stays high
// until the item is done, and its one result appears on out_data for exactly one
// cycle with out_valid high, with no way for the receiver to hold it. A clear,
// an unused mode, a skipped empty interval, a full-table insert and a query on an
// empty table are answered from the idle state without a search. A query runs a
// binary search over ceil(log2(count+1)) steps, each a memory read and then a
// compare, followed by an end check on the entry below the found point. An insert
// runs the same search, then moves each entry above the insert point up by one
// (read, then write), then stores the new entry. The memory's single read port and
// the single comparator mean that the search and the shift make one memory access
// at a time. The table needs no clearing pass after reset.
module sorted_interval_table_lookup_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sitl_pkg::in_t   in_data,
  output logic            out_valid,
  output sitl_pkg::out_t  out_data
);

  sitl_pkg::state_t state_r, state_nxt;
  sitl_pkg::in_t    item_r, item_nxt;
  logic [sitl_pkg::FRAME_W-1:0] key_r, key_nxt;
  logic [sitl_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [sitl_pkg::CNT_W-1:0]   lo_r, lo_nxt;
  logic [sitl_pkg::CNT_W-1:0]   hi_r, hi_nxt;
  logic [sitl_pkg::CNT_W-1:0]   mid_r, mid_nxt;
  logic [sitl_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  sitl_pkg::out_t               out_data_r, out_data_nxt;

  logic [sitl_pkg::CNT_W-1:0]   mid_calc;
  logic [sitl_pkg::CNT_W-1:0]   idx_dec;

  logic                         wr_en;
  logic [sitl_pkg::IDX_W-1:0]   wr_addr;
  sitl_pkg::entry_t             wr_data;
  logic [sitl_pkg::IDX_W-1:0]   rd_addr;
  sitl_pkg::entry_t             rd_data;

  logic [sitl_pkg::FRAME_W-1:0] cmp_a, cmp_b;
  logic                         cmp_lt;

  sitl_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sitl_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_dec  = idx_r - sitl_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sitl_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[sitl_pkg::IDX_W-1:0];
    wr_data       = rd_data;
    rd_addr       = '0;
    cmp_a         = key_r;
    cmp_b         = rd_data.first_frame;

    unique case (state_r)
      sitl_pkg::ST_IDLE: begin
        cmp_a = in_data.first_frame;
        cmp_b = in_data.limit_frame;
        if (start) begin
          item_nxt = in_data;
          lo_nxt   = '0;
          hi_nxt   = count_r;
          out_data_nxt = '0;
          unique case (in_data.mode)
            sitl_pkg::MODE_INSERT: begin
              key_nxt = in_data.first_frame;
              if (!cmp_lt) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.insert_status = sitl_pkg::STATUS_EMPTY;
              end else if (count_r >= sitl_pkg::DEPTH_CNT) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.insert_status = sitl_pkg::STATUS_FULL;
              end else begin
                state_nxt = sitl_pkg::ST_SEARCH;
              end
            end
            sitl_pkg::MODE_QUERY: begin
              key_nxt = in_data.frame;
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = sitl_pkg::ST_SEARCH;
              end
            end
            sitl_pkg::MODE_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      sitl_pkg::ST_SEARCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_calc;
          rd_addr   = mid_calc[sitl_pkg::IDX_W-1:0];
          state_nxt = sitl_pkg::ST_SEARCH_CMP;
        end else if (item_r.mode == sitl_pkg::MODE_QUERY) begin
          if (lo_r == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            state_nxt     = sitl_pkg::ST_IDLE;
          end else begin
            rd_addr   = lo_r[sitl_pkg::IDX_W-1:0] - sitl_pkg::IDX_W'(1);
            state_nxt = sitl_pkg::ST_CHECK;
          end
        end else begin
          idx_nxt = count_r;
          if (count_r > lo_r) begin
            state_nxt = sitl_pkg::ST_SHIFT_RD;
          end else begin
            state_nxt = sitl_pkg::ST_PLACE;
          end
        end
      end

      sitl_pkg::ST_SEARCH_CMP: begin
        if (cmp_lt) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + sitl_pkg::CNT_W'(1);
        end
        state_nxt = sitl_pkg::ST_SEARCH;
      end

      sitl_pkg::ST_CHECK: begin
        cmp_b         = rd_data.limit_frame;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        if (cmp_lt) begin
          out_data_nxt.hit     = 1'b1;
          out_data_nxt.hit_tag = rd_data.tag;
        end
        state_nxt = sitl_pkg::ST_IDLE;
      end

      sitl_pkg::ST_SHIFT_RD: begin
        rd_addr   = idx_dec[sitl_pkg::IDX_W-1:0];
        state_nxt = sitl_pkg::ST_SHIFT_WR;
      end

      sitl_pkg::ST_SHIFT_WR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_dec;
        if (idx_dec > lo_r) begin
          state_nxt = sitl_pkg::ST_SHIFT_RD;
        end else begin
          state_nxt = sitl_pkg::ST_PLACE;
        end
      end

      sitl_pkg::ST_PLACE: begin
        wr_en               = 1'b1;
        wr_addr             = lo_r[sitl_pkg::IDX_W-1:0];
        wr_data.first_frame = item_r.first_frame;
        wr_data.limit_frame = item_r.limit_frame;
        wr_data.tag         = item_r.tag;
        count_nxt           = count_r + sitl_pkg::CNT_W'(1);
        out_valid_nxt       = 1'b1;
        out_data_nxt        = '0;
        out_data_nxt.insert_status = sitl_pkg::STATUS_OK;
        state_nxt           = sitl_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = sitl_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != sitl_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/sitl_mem.sv =====
// Interval entry memory: one write port, one registered read port.
module sitl_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [sitl_pkg::IDX_W-1:0] wr_addr,
  input  sitl_pkg::entry_t           wr_data,
  input  logic [sitl_pkg::IDX_W-1:0] rd_addr,
  output sitl_pkg::entry_t           rd_data
);

  sitl_pkg::entry_t mem [sitl_pkg::TABLE_DEPTH];
  sitl_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/sitl_cmp.sv =====
// Shared frame comparator used by the sequencer's empty-interval check, search compares and end check.
module sitl_cmp (
  input  logic [sitl_pkg::FRAME_W-1:0] a,
  input  logic [sitl_pkg::FRAME_W-1:0] b,
  output logic                         lt
);

  assign lt = (a < b);

endmodule

// ===== bench/sorted_interval_table_lookup_core_test.sv =====
// Testbench for the sorted interval table lookup core: insert, query, clear and unused commands.
module sorted_interval_table_lookup_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [sitl_pkg::FRAME_W-1:0] FRAME_TOP = '1;
  localparam int ITEM_TARGET = 1350;

  typedef struct {
    sitl_pkg::in_t cmd;
    bit            drain;
  } pending_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  sitl_pkg::in_t  in_data = '0;
  logic           out_valid;
  sitl_pkg::out_t out_data;

  pending_t       command_q[$];
  sitl_pkg::out_t outcome_q[$];
  int             n_queued = 0;
  int             n_issued = 0;
  int             n_done = 0;
  int             n_accepted = 0;
  int             errors = 0;

  logic [sitl_pkg::FRAME_W-1:0] lut_start [sitl_pkg::TABLE_DEPTH];
  logic [sitl_pkg::FRAME_W-1:0] lut_end [sitl_pkg::TABLE_DEPTH];
  logic [sitl_pkg::TAG_W-1:0]   lut_tag [sitl_pkg::TABLE_DEPTH];
  int                           lut_count = 0;

  sorted_interval_table_lookup_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int first_above(input logic [sitl_pkg::FRAME_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = lut_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (key < lut_start[mid]) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  task automatic apply_command(input sitl_pkg::in_t c);
    sitl_pkg::out_t r;
    int             pos;
    int             k;
    r = '0;
    case (c.mode)
      sitl_pkg::MODE_INSERT: begin
        if (c.first_frame >= c.limit_frame) begin
          r.insert_status = sitl_pkg::STATUS_EMPTY;
        end else if (lut_count >= sitl_pkg::TABLE_DEPTH) begin
          r.insert_status = sitl_pkg::STATUS_FULL;
        end else begin
          pos = first_above(c.first_frame);
          for (k = lut_count; k > pos; k--) begin
            lut_start[k] = lut_start[k-1];
            lut_end[k] = lut_end[k-1];
            lut_tag[k] = lut_tag[k-1];
          end
          lut_start[pos] = c.first_frame;
          lut_end[pos] = c.limit_frame;
          lut_tag[pos] = c.tag;
          lut_count++;
        end
      end
      sitl_pkg::MODE_QUERY: begin
        if (lut_count > 0) begin
          pos = first_above(c.frame);
          if (pos > 0 && c.frame >= lut_start[pos-1] && c.frame < lut_end[pos-1]) begin
            r.hit = 1'b1;
            r.hit_tag = lut_tag[pos-1];
          end
        end
      end
      sitl_pkg::MODE_CLEAR: begin
        lut_count = 0;
      end
      default: ;
    endcase
    outcome_q = {outcome_q, r};
  endtask

  function automatic sitl_pkg::in_t random_cmd(input logic [1:0] mode);
    sitl_pkg::in_t c;
    c.mode = mode;
    c.first_frame = sitl_pkg::FRAME_W'($urandom);
    c.limit_frame = sitl_pkg::FRAME_W'($urandom);
    c.tag = sitl_pkg::TAG_W'($urandom);
    c.frame = sitl_pkg::FRAME_W'($urandom);
    return c;
  endfunction

  function automatic sitl_pkg::in_t insert_cmd(input logic [sitl_pkg::FRAME_W-1:0] s,
                                               input logic [sitl_pkg::FRAME_W-1:0] e,
                                               input logic [sitl_pkg::TAG_W-1:0] t);
    sitl_pkg::in_t c;
    c = random_cmd(sitl_pkg::MODE_INSERT);
    c.first_frame = s;
    c.limit_frame = e;
    c.tag = t;
    return c;
  endfunction

  function automatic sitl_pkg::in_t query_cmd(input logic [sitl_pkg::FRAME_W-1:0] f);
    sitl_pkg::in_t c;
    c = random_cmd(sitl_pkg::MODE_QUERY);
    c.frame = f;
    return c;
  endfunction

  function automatic logic [sitl_pkg::FRAME_W-1:0] span_end(
      input logic [sitl_pkg::FRAME_W-1:0] s, input int len);
    int x;
    x = int'(s) + len;
    return (x > int'(FRAME_TOP)) ? FRAME_TOP : sitl_pkg::FRAME_W'(x);
  endfunction

  task automatic queue_cmd(input sitl_pkg::in_t c, input bit drain = 1'b0);
    pending_t p;
    p.cmd = c;
    p.drain = drain;
    command_q = {command_q, p};
    n_queued++;
  endtask

  task automatic fill_table(input bit wide);
    logic [sitl_pkg::FRAME_W-1:0] s;
    int                           i;
    queue_cmd(random_cmd(sitl_pkg::MODE_CLEAR), 1'b1);
    for (i = 0; i < sitl_pkg::TABLE_DEPTH; i++) begin
      if (wide) s = sitl_pkg::FRAME_W'($urandom_range(0, 24'hFFFF00));
      else s = sitl_pkg::FRAME_W'($urandom_range(0, 63) * 64 +
                                  (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63)));
      queue_cmd(insert_cmd(s, span_end(s, $urandom_range(1, 100)),
                           sitl_pkg::TAG_W'($urandom)));
      if ($urandom_range(0, 9) == 0) begin
        queue_cmd(query_cmd(sitl_pkg::FRAME_W'($urandom_range(0, 4200))));
      end
    end
    s = sitl_pkg::FRAME_W'($urandom_range(0, 4000));
    queue_cmd(insert_cmd(s, span_end(s, 5), sitl_pkg::TAG_W'($urandom)));
    queue_cmd(insert_cmd(FRAME_TOP, 24'd0, sitl_pkg::TAG_W'($urandom)));
    queue_cmd(insert_cmd(24'd7, 24'd7, sitl_pkg::TAG_W'($urandom)));
    for (i = 0; i < 8; i++) begin
      queue_cmd(query_cmd(wide ? sitl_pkg::FRAME_W'($urandom) :
                                 sitl_pkg::FRAME_W'($urandom_range(0, 4200))));
    end
  endtask

  task automatic random_sequence(input bit drain);
    logic [sitl_pkg::FRAME_W-1:0] base;
    logic [sitl_pkg::FRAME_W-1:0] s;
    int                           n;
    int                           i;
    if ($urandom_range(0, 3) == 0) begin
      base = sitl_pkg::FRAME_W'($urandom_range(24'hFFFE00, 24'hFFFFFF));
    end else begin
      base = sitl_pkg::FRAME_W'($urandom);
    end
    if ($urandom_range(0, 9) < 7) queue_cmd(random_cmd(sitl_pkg::MODE_CLEAR), drain);
    else queue_cmd(query_cmd(base), drain);
    n = $urandom_range(1, 24);
    for (i = 0; i < n; i++) begin
      s = span_end(base, $urandom_range(0, 200));
      queue_cmd(insert_cmd(s, span_end(s, $urandom_range(0, 40)), sitl_pkg::TAG_W'($urandom)));
      if ($urandom_range(0, 2) == 0) queue_cmd(query_cmd(span_end(base, $urandom_range(0, 260))));
    end
    n = $urandom_range(2, 16);
    for (i = 0; i < n; i++) begin
      queue_cmd(query_cmd(span_end(base, $urandom_range(0, 260))));
    end
  endtask

  always @(posedge clk) begin
    bit taken;
    bit idle;
    taken = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        apply_command(in_data);
        void'(command_q.pop_front());
        n_issued++;
        n_accepted++;
      end
      if (taken || !start) begin
        idle = (n_accepted < 600 || n_accepted > 800) && ($urandom_range(0, 99) < 28);
        if (command_q.size() > 0 && !idle && !(command_q[0].drain && n_issued != n_done)) begin
          start <= 1'b1;
          in_data <= command_q[0].cmd;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sitl_pkg::out_t want;
    if (rst_n && out_valid) begin
      n_done <= n_done + 1;
      if (outcome_q.size() == 0) begin
        $error("unexpected result: hit %0d hit_tag %0h insert_status %0d",
               out_data.hit, out_data.hit_tag, out_data.insert_status);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
          errors++;
        end
        if (out_data.hit_tag !== want.hit_tag) begin
          $error("hit_tag: expected %0h, got %0h", want.hit_tag, out_data.hit_tag);
          errors++;
        end
        if (out_data.insert_status !== want.insert_status) begin
          $error("insert_status: expected %0d, got %0d", want.insert_status,
                 out_data.insert_status);
          errors++;
        end
      end
    end
  end

  initial begin
    int n_seq;
    queue_cmd(query_cmd(24'd10));
    queue_cmd(insert_cmd(24'd0, FRAME_TOP, 12'hFFF));
    queue_cmd(insert_cmd(24'd5, 24'd5, 12'h123));
    queue_cmd(insert_cmd(FRAME_TOP, 24'd0, 12'h456));
    queue_cmd(query_cmd(24'd0));
    queue_cmd(query_cmd(24'hFFFFFE));
    queue_cmd(query_cmd(FRAME_TOP));
    queue_cmd(random_cmd(sitl_pkg::MODE_CLEAR));
    queue_cmd(query_cmd(24'd10));
    queue_cmd(insert_cmd(24'd100, 24'd200, 12'd1));
    queue_cmd(insert_cmd(24'd100, 24'd300, 12'd2));
    queue_cmd(query_cmd(24'd150));
    queue_cmd(query_cmd(24'd250));
    queue_cmd(random_cmd(sitl_pkg::MODE_CLEAR));
    queue_cmd(insert_cmd(24'd1000, 24'd2000, 12'd7));
    queue_cmd(query_cmd(24'd999));
    queue_cmd(query_cmd(24'd1000));
    queue_cmd(query_cmd(24'd1999));
    queue_cmd(query_cmd(24'd2000));
    queue_cmd(insert_cmd(24'd500, 24'd5000, 12'd9));
    queue_cmd(query_cmd(24'd1500));
    queue_cmd(query_cmd(24'd3000));
    queue_cmd(random_cmd(MODE_UNUSED));
    queue_cmd(random_cmd(MODE_UNUSED));
    queue_cmd(query_cmd(24'd600));

    fill_table(1'b0);
    n_seq = 0;
    while (n_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_cmd(random_cmd(2'($urandom_range(0, 3))));
      end else begin
        random_sequence(n_seq == 0 || $urandom_range(0, 9) == 0);
        n_seq++;
        if (n_seq == 20) fill_table(1'b1);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (command_q.size() != 0 || n_issued != n_done || outcome_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sitl_pkg.sv
rtl/core/sitl_mem.sv
rtl/core/sitl_cmp.sv
rtl/core/sorted_interval_table_lookup_core.sv
bench/sorted_interval_table_lookup_core_test.sv
